@@ rtl/core/assert_macros.svh @@
// assertion macros used by the checker file gbpe_checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// next-cycle implication, masked while reset is asserted
`define GBPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gbpe assertion failed");

// condition that must hold on the cycle after a reset cycle
`define GBPE_ASSERT_AFTER_RST(lbl, clk, rst_n, cons) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error("gbpe reset assertion failed");

`endif

@@ rtl/core/gbpe_pkg.sv @@
// package for the glyph bitmap pixel expander: codes, config and queue types
// no dependencies
`timescale 1ns / 1ps

package gbpe_pkg;

  // command codes of an input item
  localparam logic CMD_HEADER = 1'b0;
  localparam logic CMD_DATA   = 1'b1;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_TWO_BIT_MODE  = 2'd0,
    CFG_ROTATED_CW    = 2'd1,
    CFG_FONT_ASCENDER = 2'd2,
    CFG_INK_COLOR     = 2'd3
  } cfg_addr_t;

  // colour codes
  localparam logic [2:0] INK_BLACK = 3'd0;

  // grey level mask and the white level in 2-bit mode
  localparam logic [1:0] LEVEL_MASK = 2'h3;

  // pixels per byte
  localparam logic [3:0] SLOTS_1BPP = 4'd8;
  localparam logic [3:0] SLOTS_2BPP = 4'd4;

  // default depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic       two_bit_mode;
    logic       rotated_cw;
    logic [7:0] font_ascender;
    logic [2:0] ink_color;
  } cfg_t;

  // one classified item as it waits for the back end
  typedef struct packed {
    logic        is_hdr;
    logic [15:0] outer_base;
    logic [15:0] inner_base;
    logic [7:0]  width;
    logic [15:0] total;
    logic [7:0]  bmp;
  } q_entry_t;

endpackage

@@ rtl/core/gbpe_if.sv @@
// valid/ready channel interfaces for glyph items and drawn pixels
// no dependencies
`timescale 1ns / 1ps

interface gbpe_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic signed [15:0] cursor_x;
  logic signed [15:0] cursor_y;
  logic signed [7:0]  glyph_left;
  logic signed [7:0]  glyph_top;
  logic [7:0]         glyph_width;
  logic [7:0]         glyph_height;
  logic [7:0]         bitmap_byte;

  modport source (
    output valid, cmd, cursor_x, cursor_y, glyph_left, glyph_top,
           glyph_width, glyph_height, bitmap_byte,
    input  ready
  );
  modport sink (
    input  valid, cmd, cursor_x, cursor_y, glyph_left, glyph_top,
           glyph_width, glyph_height, bitmap_byte,
    output ready
  );
endinterface

interface gbpe_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pixel_x;
  logic signed [15:0] pixel_y;
  logic [2:0]         pixel_color;
  logic               last_of_byte;

  modport source (
    output valid, pixel_x, pixel_y, pixel_color, last_of_byte,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, pixel_color, last_of_byte,
    output ready
  );
endinterface

@@ rtl/core/glyph_bitmap_pixel_expander.sv @@
// top level of the glyph bitmap pixel expander: config registers, front and back
// depends on gbpe_pkg, gbpe_if, gbpe_front and gbpe_back
//
//  channel  | direction | handshake     | payload
//  ---------+-----------+---------------+--------------------------------------
//  in_ch    | in        | valid/ready   | cmd, cursor, offsets, size, bitmap byte
//  out_ch   | out       | valid/ready   | pixel_x, pixel_y, pixel_color, last_of_byte
//  cfg_*    | in        | write enable  | cfg_addr index, cfg_wdata value
//
// a header item only loads the glyph state in the back end; a data byte is walked
// over its pixels still inside the glyph (up to 8 at 1 bit, 4 at 2 bits) by the
// back end's pixel sequencer, which handles one pixel a cycle unless a drawn pixel waits on a stalled output.
// an accepted byte waits in the queue, then loads the sequencer registers, and each drawn pixel the output register.
// reset is synchronous and clears the queue, the glyph state and the config.
// a queue of QDEPTH items lets input keep flowing while the output stalls.
`timescale 1ns / 1ps

module glyph_bitmap_pixel_expander #(
  parameter int QDEPTH = gbpe_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  gbpe_in_if.sink    in_ch,
  gbpe_out_if.source out_ch,
  input  logic       cfg_we,
  input  logic [1:0] cfg_addr,
  input  logic [7:0] cfg_wdata
);

  gbpe_pkg::cfg_t     cfg_r, cfg_nxt;
  logic               q_valid;
  logic               q_pop;
  gbpe_pkg::q_entry_t q_head;

  // configuration register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (gbpe_pkg::cfg_addr_t'(cfg_addr))
        gbpe_pkg::CFG_TWO_BIT_MODE:  cfg_nxt.two_bit_mode  = cfg_wdata[0];
        gbpe_pkg::CFG_ROTATED_CW:    cfg_nxt.rotated_cw    = cfg_wdata[0];
        gbpe_pkg::CFG_FONT_ASCENDER: cfg_nxt.font_ascender = cfg_wdata;
        gbpe_pkg::CFG_INK_COLOR:     cfg_nxt.ink_color     = cfg_wdata[2:0];
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  gbpe_front #(
    .QDEPTH (QDEPTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop)
  );

  gbpe_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

@@ rtl/core/gbpe_front.sv @@
// front end: accepts items, works out header placement, queues entries
// depends on gbpe_pkg and gbpe_if
`timescale 1ns / 1ps

module gbpe_front #(
  parameter int QDEPTH = gbpe_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  gbpe_in_if.sink            in_ch,
  input  gbpe_pkg::cfg_t     cfg,
  output logic               q_valid,
  output gbpe_pkg::q_entry_t q_head,
  input  logic               q_pop
);

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  gbpe_pkg::q_entry_t mem_r [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  gbpe_pkg::q_entry_t entry;
  logic               push;
  logic [15:0]        left_ext;
  logic [15:0]        top_ext;

  assign in_ch.ready = (count_r != CNT_W'(QDEPTH));
  assign push        = in_ch.valid & in_ch.ready;
  assign q_valid     = (count_r != '0);
  assign q_head      = mem_r[rd_ptr_r];

  // classify the item and place a header
  always_comb begin
    left_ext         = {{8{in_ch.glyph_left[7]}}, in_ch.glyph_left};
    top_ext          = {{8{in_ch.glyph_top[7]}}, in_ch.glyph_top};
    entry.is_hdr     = (in_ch.cmd == gbpe_pkg::CMD_HEADER);
    entry.width      = in_ch.glyph_width;
    entry.total      = {8'd0, in_ch.glyph_width} * {8'd0, in_ch.glyph_height};
    entry.bmp        = in_ch.bitmap_byte;
    if (cfg.rotated_cw) begin
      entry.outer_base = in_ch.cursor_x + {8'd0, cfg.font_ascender} - top_ext;
      entry.inner_base = in_ch.cursor_y - left_ext;
    end else begin
      entry.outer_base = in_ch.cursor_y - top_ext;
      entry.inner_base = in_ch.cursor_x + left_ext;
    end
  end

  // queue pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= entry;
    end
  end

endmodule

@@ rtl/core/gbpe_back.sv @@
// back end: walks the pixels of each byte, one a cycle unless the output stalls, into the output register
// depends on gbpe_pkg and gbpe_if
`timescale 1ns / 1ps

module gbpe_back (
  input  logic               clk,
  input  logic               rst_n,
  input  gbpe_pkg::cfg_t     cfg,
  input  logic               q_valid,
  input  gbpe_pkg::q_entry_t q_head,
  output logic               q_pop,
  gbpe_out_if.source         out_ch
);

  logic        busy_r, busy_nxt;
  logic [2:0]  slot_r, slot_nxt;
  logic [3:0]  nvalid_r, nvalid_nxt;
  logic [2:0]  lastidx_r, lastidx_nxt;
  logic [7:0]  draw_r, draw_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic [7:0]  col_r, col_nxt;
  logic [7:0]  row_r, row_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [15:0] outer_r, outer_nxt;
  logic [15:0] inner_r, inner_nxt;
  logic [7:0]  width_r, width_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [15:0] px_r, px_nxt;
  logic [15:0] py_r, py_nxt;
  logic [2:0]  color_r, color_nxt;
  logic        last_r, last_nxt;

  logic        cur_draw;
  logic        can_load;
  logic        step;
  logic        done;
  logic [15:0] rem_step;
  logic [3:0]  slots;
  logic [3:0]  nv;
  logic [7:0]  dvec;
  logic [2:0]  lidx;
  logic [7:0]  shifted;
  logic [1:0]  level;
  logic [7:0]  col_adv;

  assign cur_draw = draw_r[slot_r];
  assign can_load = !out_valid_r || out_ch.ready;
  assign step     = busy_r && (!cur_draw || can_load);
  assign done     = step && ({1'b0, slot_r} + 4'd1 == nvalid_r);
  assign q_pop    = q_valid && (!busy_r || done);
  assign rem_step = step ? rem_r - 16'd1 : rem_r;
  assign col_adv  = col_r + 8'd1;

  // draw mask and last drawn pixel of a byte about to start
  always_comb begin
    slots = cfg.two_bit_mode ? gbpe_pkg::SLOTS_2BPP : gbpe_pkg::SLOTS_1BPP;
    nv    = (rem_step >= {12'd0, slots}) ? slots : rem_step[3:0];
    lidx  = '0;
    for (int k = 0; k < 8; k++) begin
      if (cfg.two_bit_mode) begin
        dvec[k] = (k < 4) && (q_head.bmp[7-2*(k%4) -: 2] != 2'b00);
      end else begin
        dvec[k] = q_head.bmp[7-k];
      end
      dvec[k] = dvec[k] && (4'(k) < nv);
      if (dvec[k]) begin
        lidx = 3'(k);
      end
    end
  end

  // colour of the current pixel
  always_comb begin
    shifted = byte_r << {slot_r[1:0], 1'b0};
    level   = gbpe_pkg::LEVEL_MASK - shifted[7:6];
    if (cfg.two_bit_mode && cfg.ink_color == gbpe_pkg::INK_BLACK) begin
      color_nxt = {1'b0, level};
    end else begin
      color_nxt = cfg.ink_color;
    end
  end

  // sequencer over the pixels of a byte
  always_comb begin
    busy_nxt    = busy_r;
    slot_nxt    = slot_r;
    nvalid_nxt  = nvalid_r;
    lastidx_nxt = lastidx_r;
    draw_nxt    = draw_r;
    byte_nxt    = byte_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    rem_nxt     = rem_r;
    outer_nxt   = outer_r;
    inner_nxt   = inner_r;
    width_nxt   = width_r;
    if (step) begin
      slot_nxt = slot_r + 3'd1;
      rem_nxt  = rem_step;
      if (col_adv >= width_r) begin
        col_nxt = '0;
        row_nxt = row_r + 8'd1;
      end else begin
        col_nxt = col_adv;
      end
      if (done) begin
        busy_nxt = 1'b0;
      end
    end
    if (q_pop) begin
      if (q_head.is_hdr) begin
        busy_nxt  = 1'b0;
        outer_nxt = q_head.outer_base;
        inner_nxt = q_head.inner_base;
        width_nxt = q_head.width;
        rem_nxt   = q_head.total;
        col_nxt   = '0;
        row_nxt   = '0;
      end else begin
        busy_nxt    = (nv != 4'd0);
        slot_nxt    = '0;
        nvalid_nxt  = nv;
        lastidx_nxt = lidx;
        draw_nxt    = dvec;
        byte_nxt    = q_head.bmp;
      end
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (cfg.rotated_cw) begin
      px_nxt = outer_r + {8'd0, row_r};
      py_nxt = inner_r - {8'd0, col_r};
    end else begin
      px_nxt = inner_r + {8'd0, col_r};
      py_nxt = outer_r + {8'd0, row_r};
    end
    last_nxt = (slot_r == lastidx_r);
    if (step && cur_draw) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
      rem_r       <= '0;
      outer_r     <= '0;
      inner_r     <= '0;
      width_r     <= '0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      rem_r       <= rem_nxt;
      outer_r     <= outer_nxt;
      inner_r     <= inner_nxt;
      width_r     <= width_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    slot_r    <= slot_nxt;
    nvalid_r  <= nvalid_nxt;
    lastidx_r <= lastidx_nxt;
    draw_r    <= draw_nxt;
    byte_r    <= byte_nxt;
    if (step && cur_draw) begin
      px_r    <= px_nxt;
      py_r    <= py_nxt;
      color_r <= color_nxt;
      last_r  <= last_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pixel_x      = px_r;
  assign out_ch.pixel_y      = py_r;
  assign out_ch.pixel_color  = color_r;
  assign out_ch.last_of_byte = last_r;

endmodule

@@ rtl/core/gbpe_checker.sv @@
// port-level checks for the glyph bitmap pixel expander, bound to the top level
// depends on assert_macros.svh and glyph_bitmap_pixel_expander
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gbpe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_pixel_x,
  input logic [15:0] out_pixel_y,
  input logic [2:0]  out_pixel_color,
  input logic        out_last
);

  logic        stalled;
  logic [35:0] out_payload;
  assign stalled     = out_valid && !out_ready;
  assign out_payload = {out_pixel_x, out_pixel_y, out_pixel_color, out_last};

  // a stalled pixel stays offered
  `GBPE_ASSERT_NEXT(a_out_hold, clk, rst_n, stalled, out_valid)

  // a stalled pixel keeps its payload
  `GBPE_ASSERT_NEXT(a_out_stable, clk, rst_n, stalled, $stable(out_payload))

  // reset empties the output register
  `GBPE_ASSERT_AFTER_RST(a_rst_out, clk, rst_n, !out_valid)

  // reset empties the queue so input is taken right away
  `GBPE_ASSERT_AFTER_RST(a_rst_in, clk, rst_n, in_ready)

endmodule

bind glyph_bitmap_pixel_expander gbpe_checker u_gbpe_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_pixel_x     (out_ch.pixel_x),
  .out_pixel_y     (out_ch.pixel_y),
  .out_pixel_color (out_ch.pixel_color),
  .out_last        (out_ch.last_of_byte)
);
